>>> hw/rtl/prs_pkg.sv
`default_nettype none

package prs_pkg;

   // Word kinds on the request channel.
   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_START = 2'd1;
   localparam logic [1:0] KIND_STOP  = 2'd2;

   // Configuration register indexes.
   localparam int unsigned CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_RAIL_LEVELS  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GOOD_LEVELS  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LEVEL_COUNT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SETTLE_TICKS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CHECK_TICKS  = 3'd4;

   // Fixed field widths.
   localparam int unsigned LEVEL_W   = 3;
   localparam int unsigned TICKS_W   = 16;
   localparam int unsigned RAIL_OUT_W = 16;

   // Register reset values.
   localparam logic [LEVEL_W-1:0] LEVEL_COUNT_RESET = 3'd6;
   localparam logic [TICKS_W-1:0] TICKS_RESET       = 16'd1000;

   // Sequencer phase.
   typedef enum logic [1:0] {
      PH_IDLE,
      PH_SETTLE,
      PH_POWERED
   } phase_type;

   // Status fields of one response word, apart from the rail enables.
   typedef struct packed {
      logic [LEVEL_W-1:0] current_level;
      logic               powered_up;
      logic               fault_pulse;
      logic [LEVEL_W-1:0] failed_level;
      logic               red_led;
   } status_type;

endpackage

`default_nettype wire

>>> hw/rtl/prs_if.sv
`default_nettype none

// Request channel: kind and sampled power-good inputs.
interface prs_req_if #(
   parameter int unsigned NUM_GOODS = 14
);
   logic                 valid;
   logic                 ready;
   logic [1:0]           kind;
   logic [NUM_GOODS-1:0] power_good;

   modport source (output valid, output kind, output power_good, input ready);
   modport sink   (input valid, input kind, input power_good, output ready);
endinterface

// Response channel: rail enables and sequencer status.
interface prs_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] rail_enable;
   logic [2:0]  current_level;
   logic        powered_up;
   logic        fault_pulse;
   logic [2:0]  failed_level;
   logic        red_led;

   modport source (output valid, output rail_enable, output current_level,
                   output powered_up, output fault_pulse, output failed_level,
                   output red_led, input ready);
   modport sink   (input valid, input rail_enable, input current_level,
                   input powered_up, input fault_pulse, input failed_level,
                   input red_led, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/prs_core.sv
`default_nettype none

module prs_core
   import prs_pkg::*;
#(
   parameter int unsigned NUM_RAILS  = 16,
   parameter int unsigned NUM_GOODS  = 14,
   parameter int unsigned MAX_LEVELS = 6,
   parameter int unsigned TIMER_BITS = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         step,
   input  wire logic [1:0]                   kind,
   input  wire logic [NUM_GOODS-1:0]         power_good,
   input  wire logic [LEVEL_W*NUM_RAILS-1:0] rail_levels,
   input  wire logic [LEVEL_W*NUM_GOODS-1:0] good_levels,
   input  wire logic [LEVEL_W-1:0]           level_count,
   input  wire logic [TICKS_W-1:0]           settle_ticks,
   input  wire logic [TICKS_W-1:0]           check_ticks,
   output logic      [NUM_RAILS-1:0]         enable_next,
   output status_type                        status_next
);

   localparam logic [LEVEL_W-1:0] TOP_MAX = LEVEL_W'(MAX_LEVELS);
   localparam logic [LEVEL_W-1:0] LEVEL_ONE = 3'd1;

   phase_type             phase_ff, phase_in;
   logic [LEVEL_W-1:0]    level_ff, level_in;
   logic [TIMER_BITS-1:0] wait_ff, wait_in;
   logic [NUM_RAILS-1:0]  enable_ff, enable_in;
   logic [LEVEL_W-1:0]    fail_ff, fail_in;
   logic                  led_ff, led_in;
   logic                  fault;

   logic [LEVEL_W-1:0]    top;
   logic [LEVEL_W-1:0]    lvl_eff;
   logic [LEVEL_W-1:0]    upto;
   logic [LEVEL_W-1:0]    next_level;
   logic [7:0]            bad_at;
   logic [LEVEL_W-1:0]    bad;
   logic [LEVEL_W-1:0]    at;
   logic [TIMER_BITS-1:0] settle_reload;
   logic [TIMER_BITS-1:0] check_reload;
   logic [NUM_RAILS-1:0]  on_first;
   logic [NUM_RAILS-1:0]  on_next;
   logic [NUM_RAILS-1:0]  off_from;

   // Timer reload: the register taken modulo the timer width, zero acts as one.
   function automatic logic [TIMER_BITS-1:0] reload(input logic [TICKS_W-1:0] ticks);
      logic [TIMER_BITS-1:0] v;
      v = TIMER_BITS'(ticks);
      if (v == '0) begin
         v = TIMER_BITS'(1);
      end
      return v;
   endfunction

   // Level limits for this word.
   always_comb begin
      if (level_count == '0) begin
         top = LEVEL_ONE;
      end else if (level_count > TOP_MAX) begin
         top = TOP_MAX;
      end else begin
         top = level_count;
      end
      lvl_eff       = (level_ff > top) ? top : level_ff;
      upto          = (phase_ff == PH_POWERED) ? top : lvl_eff;
      next_level    = lvl_eff + LEVEL_ONE;
      settle_reload = reload(settle_ticks);
      check_reload  = reload(check_ticks);
   end

   // Power-good check: mark each level holding a bad input, then take the lowest.
   always_comb begin
      logic [LEVEL_W-1:0] g;
      bad_at = '0;
      for (int j = 0; j < NUM_GOODS; j++) begin
         g = good_levels[LEVEL_W*j +: LEVEL_W];
         if (g != '0 && g <= upto && !power_good[j]) begin
            bad_at[g] = 1'b1;
         end
      end
      bad = '0;
      for (int l = 7; l >= 1; l--) begin
         if (bad_at[l]) begin
            bad = LEVEL_W'(l);
         end
      end
      at = (phase_ff == PH_POWERED) ? bad : lvl_eff;
   end

   // Rail masks by level, one parallel compare per rail.
   always_comb begin
      logic [LEVEL_W-1:0] r;
      for (int i = 0; i < NUM_RAILS; i++) begin
         r           = rail_levels[LEVEL_W*i +: LEVEL_W];
         on_first[i] = (r == LEVEL_ONE);
         on_next[i]  = (r == next_level);
         off_from[i] = (r >= at);
      end
   end

   // Next state for the accepted word.
   always_comb begin
      phase_in  = phase_ff;
      level_in  = level_ff;
      wait_in   = wait_ff;
      enable_in = enable_ff;
      fail_in   = fail_ff;
      led_in    = led_ff;
      fault     = 1'b0;
      case (kind)
         KIND_START: begin
            fail_in   = '0;
            led_in    = 1'b0;
            phase_in  = PH_SETTLE;
            level_in  = LEVEL_ONE;
            enable_in = enable_ff | on_first;
            wait_in   = settle_reload;
         end
         KIND_STOP: begin
            phase_in  = PH_IDLE;
            level_in  = '0;
            wait_in   = '0;
            enable_in = '0;
         end
         KIND_TICK: begin
            if (phase_ff != PH_IDLE) begin
               if (wait_ff > TIMER_BITS'(1)) begin
                  wait_in = wait_ff - TIMER_BITS'(1);
               end else if (bad != '0) begin
                  // Failed check: drop the failing level and above, restart.
                  fault     = 1'b1;
                  fail_in   = at;
                  led_in    = ~led_ff;
                  phase_in  = PH_SETTLE;
                  level_in  = LEVEL_ONE;
                  enable_in = (enable_ff & ~off_from) | on_first;
                  wait_in   = settle_reload;
               end else if (phase_ff == PH_POWERED || lvl_eff >= top) begin
                  phase_in = PH_POWERED;
                  level_in = lvl_eff;
                  wait_in  = check_reload;
               end else begin
                  level_in  = next_level;
                  enable_in = enable_ff | on_next;
                  wait_in   = settle_reload;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Sequencer state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         level_ff  <= '0;
         wait_ff   <= '0;
         enable_ff <= '0;
         fail_ff   <= '0;
         led_ff    <= 1'b0;
      end else if (step) begin
         phase_ff  <= phase_in;
         level_ff  <= level_in;
         wait_ff   <= wait_in;
         enable_ff <= enable_in;
         fail_ff   <= fail_in;
         led_ff    <= led_in;
      end
   end

   // The response shows the state after the word.
   always_comb begin
      enable_next                = enable_in;
      status_next.current_level  = level_in;
      status_next.powered_up     = (phase_in == PH_POWERED);
      status_next.fault_pulse    = fault;
      status_next.failed_level   = fail_in;
      status_next.red_led        = led_in;
   end

`ifndef SYNTHESIS
   a_idle_all_off: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> (level_ff == '0 && enable_ff == '0))
      else $error("idle sequencer has a level or rails on");

   a_fault_restarts: assert property (@(posedge clock) disable iff (reset)
      (step && fault) |=> (phase_ff == PH_SETTLE && level_ff == LEVEL_ONE
                           && fail_ff != '0))
      else $error("failed check did not restart at level one");

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level_ff <= TOP_MAX)
      else $error("sequencer level beyond the last level");

   a_running_level: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_IDLE) |-> (level_ff != '0))
      else $error("running sequencer at level zero");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/power_rail_sequencer.sv
// Power rail sequencer: brings supply rails up level by level and monitors them.
// A response word is valid in the cycle after its request is accepted. One word
// per cycle unless rsp stalls; the next-state logic is one pass of parallel
// per-rail and per-input level compares between the state and response registers.
// Reset: synchronous, active high; all rails off, idle, registers at defaults.
`default_nettype none

module power_rail_sequencer
   import prs_pkg::*;
#(
   parameter int unsigned NUM_RAILS  = 16,
   parameter int unsigned NUM_GOODS  = 14,
   parameter int unsigned MAX_LEVELS = 6,
   parameter int unsigned TIMER_BITS = 16,
   localparam int unsigned RAIL_LVL_W = LEVEL_W * NUM_RAILS,
   localparam int unsigned GOOD_LVL_W = LEVEL_W * NUM_GOODS,
   localparam int unsigned LVL_MAX_W  = (RAIL_LVL_W > GOOD_LVL_W) ? RAIL_LVL_W : GOOD_LVL_W,
   localparam int unsigned CSR_W      = (LVL_MAX_W > TICKS_W) ? LVL_MAX_W : TICKS_W
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   prs_req_if.sink                   req,
   prs_rsp_if.source                 rsp,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata
);

   logic [RAIL_LVL_W-1:0] rail_levels_ff;
   logic [GOOD_LVL_W-1:0] good_levels_ff;
   logic [LEVEL_W-1:0]    level_count_ff;
   logic [TICKS_W-1:0]    settle_ticks_ff;
   logic [TICKS_W-1:0]    check_ticks_ff;

   logic                  step;
   logic [NUM_RAILS-1:0]  enable_next;
   status_type            status_next;
   logic [NUM_RAILS+RAIL_OUT_W-1:0] enable_wide;

   logic                  rsp_valid_ff;
   logic [RAIL_OUT_W-1:0] rail_enable_ff;
   status_type            status_ff;
   logic                  led_shadow_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         rail_levels_ff  <= '0;
         good_levels_ff  <= '0;
         level_count_ff  <= LEVEL_COUNT_RESET;
         settle_ticks_ff <= TICKS_RESET;
         check_ticks_ff  <= TICKS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_RAIL_LEVELS:  rail_levels_ff  <= csr_wdata[RAIL_LVL_W-1:0];
            CSR_GOOD_LEVELS:  good_levels_ff  <= csr_wdata[GOOD_LVL_W-1:0];
            CSR_LEVEL_COUNT:  level_count_ff  <= csr_wdata[LEVEL_W-1:0];
            CSR_SETTLE_TICKS: settle_ticks_ff <= csr_wdata[TICKS_W-1:0];
            CSR_CHECK_TICKS:  check_ticks_ff  <= csr_wdata[TICKS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // A word is taken whenever the response register is empty or being drained.
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign step      = req.valid && req.ready;

   prs_core #(
      .NUM_RAILS  (NUM_RAILS),
      .NUM_GOODS  (NUM_GOODS),
      .MAX_LEVELS (MAX_LEVELS),
      .TIMER_BITS (TIMER_BITS)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .kind         (req.kind),
      .power_good   (req.power_good),
      .rail_levels  (rail_levels_ff),
      .good_levels  (good_levels_ff),
      .level_count  (level_count_ff),
      .settle_ticks (settle_ticks_ff),
      .check_ticks  (check_ticks_ff),
      .enable_next  (enable_next),
      .status_next  (status_next)
   );

   // Only the low rails fit the response word; fewer rails are zero padded.
   assign enable_wide = {{RAIL_OUT_W{1'b0}}, enable_next};

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rail_enable_ff <= enable_wide[RAIL_OUT_W-1:0];
         status_ff      <= status_next;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.rail_enable   = rail_enable_ff;
   assign rsp.current_level = status_ff.current_level;
   assign rsp.powered_up    = status_ff.powered_up;
   assign rsp.fault_pulse   = status_ff.fault_pulse;
   assign rsp.failed_level  = status_ff.failed_level;
   assign rsp.red_led       = status_ff.red_led;

   // Last delivered LED state, kept for the toggle check.
   always_ff @(posedge clock) begin
      if (reset) begin
         led_shadow_ff <= 1'b0;
      end else if (step) begin
         led_shadow_ff <= status_next.red_led;
      end
   end

`ifndef SYNTHESIS
   a_accept_gives_word: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid_ff)
      else $error("accepted word produced no response");

   a_fault_toggles_led: assert property (@(posedge clock) disable iff (reset)
      (step && status_next.fault_pulse) |=> (status_ff.red_led != $past(led_shadow_ff)))
      else $error("fault did not toggle the red LED");

   a_no_fault_while_powered: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff.fault_pulse) |-> (!status_ff.powered_up
                                                   && status_ff.current_level == 3'd1))
      else $error("fault response not restarted at level one");
`endif

endmodule

`default_nettype wire

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import prs_pkg::*;

   localparam int unsigned RAIL_COUNT   = 16;
   localparam int unsigned GOOD_COUNT   = 14;
   localparam int unsigned LEVEL_LIMIT  = 6;
   localparam int unsigned CSR_DATA_W   = 48;
   localparam int unsigned PHASE_COUNT  = 14;
   localparam int unsigned PHASE_WORDS  = 75;
   localparam int unsigned HOLD_AT      = 300;
   localparam int unsigned HOLD_CYCLES  = 200;
   localparam int unsigned STALL_LIMIT  = 2000;
   localparam logic [1:0]  KIND_UNUSED  = 2'd3;

   // One response word as the sequencer reports it.
   typedef struct packed {
      logic [RAIL_OUT_W-1:0] rail_enable;
      status_type            status;
   } rail_report_type;

   // One step of the bring-up table; typed rows carry their result inline.
   typedef struct {
      logic [1:0]            kind;
      logic [GOOD_COUNT-1:0] power_good;
      bit                    typed;
      logic [15:0]           rails;
      logic [2:0]            level;
      logic                  up;
      logic                  fault;
      logic [2:0]            failed;
      logic                  led;
   } bring_up_step_type;

   localparam int unsigned STEP_COUNT = 18;

   // Rails 0 and 2 sit at level 1, rail 1 at level 2, rail 15 at level 7.
   // Good 0 is level 1, good 1 is level 2, good 13 is level 7 and never checked.
   bring_up_step_type bring_up_steps [STEP_COUNT] = '{
      '{KIND_TICK,   14'h0000, 1'b1, 16'h0000, 3'd0, 1'b0, 1'b0, 3'd0, 1'b0},
      '{KIND_UNUSED, 14'h3FFF, 1'b1, 16'h0000, 3'd0, 1'b0, 1'b0, 3'd0, 1'b0},
      '{KIND_STOP,   14'h3FFF, 1'b1, 16'h0000, 3'd0, 1'b0, 1'b0, 3'd0, 1'b0},
      '{KIND_START,  14'h0000, 1'b1, 16'h0005, 3'd1, 1'b0, 1'b0, 3'd0, 1'b0},
      '{KIND_TICK,   14'h0000, 1'b0, 16'h0000, 3'd0, 1'b0, 1'b0, 3'd0, 1'b0},
      '{KIND_TICK,   14'h3FFF, 1'b0, 16'h0000, 3'd0, 1'b0, 1'b0, 3'd0, 1'b0},
      '{KIND_TICK,   14'h0000, 1'b0, 16'h0000, 3'd0, 1'b0, 1'b0, 3'd0, 1'b0},
      '{KIND_TICK,   14'h0001, 1'b0, 16'h0000, 3'd0, 1'b0, 1'b0, 3'd0, 1'b0},
      '{KIND_TICK,   14'h3FFF, 1'b0, 16'h0000, 3'd0, 1'b0, 1'b0, 3'd0, 1'b0},
      '{KIND_TICK,   14'h3FFF, 1'b0, 16'h0000, 3'd0, 1'b0, 1'b0, 3'd0, 1'b0},
      '{KIND_TICK,   14'h3FFF, 1'b0, 16'h0000, 3'd0, 1'b0, 1'b0, 3'd0, 1'b0},
      '{KIND_TICK,   14'h1FFF, 1'b0, 16'h0000, 3'd0, 1'b0, 1'b0, 3'd0, 1'b0},
      '{KIND_TICK,   14'h3FFF, 1'b0, 16'h0000, 3'd0, 1'b0, 1'b0, 3'd0, 1'b0},
      '{KIND_TICK,   14'h3FFE, 1'b0, 16'h0000, 3'd0, 1'b0, 1'b0, 3'd0, 1'b0},
      '{KIND_START,  14'h3FFF, 1'b0, 16'h0000, 3'd0, 1'b0, 1'b0, 3'd0, 1'b0},
      '{KIND_STOP,   14'h2AAA, 1'b1, 16'h0000, 3'd0, 1'b0, 1'b0, 3'd0, 1'b0},
      '{KIND_TICK,   14'h0000, 1'b1, 16'h0000, 3'd0, 1'b0, 1'b0, 3'd0, 1'b0},
      '{KIND_UNUSED, 14'h1555, 1'b1, 16'h0000, 3'd0, 1'b0, 1'b0, 3'd0, 1'b0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   prs_req_if #(.NUM_GOODS(GOOD_COUNT)) req_bus ();
   prs_rsp_if rsp_bus ();

   power_rail_sequencer u_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .rsp       (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Register copies, updated as each register write goes out.
   logic [47:0] cfg_rail_levels = '0;
   logic [41:0] cfg_good_levels = '0;
   logic [2:0]  cfg_level_count = LEVEL_COUNT_RESET;
   logic [15:0] cfg_settle      = TICKS_RESET;
   logic [15:0] cfg_check       = TICKS_RESET;

   // Sequencer state as predicted.
   phase_type   seq_phase      = PH_IDLE;
   logic [2:0]  seq_level      = '0;
   logic [15:0] seq_wait       = '0;
   logic [15:0] seq_rails      = '0;
   logic [2:0]  seq_fail_level = '0;
   logic        seq_led        = 1'b0;

   rail_report_type pending_reports [$];
   int unsigned  error_count = 0;
   int unsigned  quiet_cycles = 0;
   bit           send_idle_on = 1'b1;

   task automatic report_error(input string msg);
      $display("%0t: mismatch: %s", $time, msg);
      error_count++;
   endtask

   function automatic logic [2:0] level_field(input logic [47:0] levels, input int unsigned idx);
      return levels[3*idx +: 3];
   endfunction

   function automatic logic [15:0] wait_reload(input logic [15:0] ticks);
      return (ticks == '0) ? 16'd1 : ticks;
   endfunction

   // Number of levels in use; out-of-range counts are pulled into 1..6.
   function automatic logic [2:0] levels_in_use();
      if (cfg_level_count == 3'd0) return 3'd1;
      if (cfg_level_count > LEVEL_LIMIT) return 3'(LEVEL_LIMIT);
      return cfg_level_count;
   endfunction

   function automatic void rails_up(input logic [2:0] lv);
      int unsigned i;
      for (i = 0; i < RAIL_COUNT; i++) begin
         if (level_field(cfg_rail_levels, i) == lv) seq_rails[i] = 1'b1;
      end
   endfunction

   function automatic void rails_down_from(input logic [2:0] lv);
      int unsigned i;
      for (i = 0; i < RAIL_COUNT; i++) begin
         if (level_field(cfg_rail_levels, i) >= lv) seq_rails[i] = 1'b0;
      end
   endfunction

   // Lowest level up to the limit with a bad power-good input, zero if none.
   function automatic logic [2:0] lowest_bad_level(input logic [2:0] upto,
                                                   input logic [GOOD_COUNT-1:0] pg);
      int unsigned j;
      logic [2:0]  g;
      logic [2:0]  worst;
      worst = '0;
      for (j = 0; j < GOOD_COUNT; j++) begin
         g = level_field({6'd0, cfg_good_levels}, j);
         if (g != '0 && g <= upto && !pg[j] && (worst == '0 || g < worst)) worst = g;
      end
      return worst;
   endfunction

   function automatic void restart_at_level_one();
      seq_phase = PH_SETTLE;
      seq_level = 3'd1;
      rails_up(3'd1);
      seq_wait = wait_reload(cfg_settle);
   endfunction

   // Applies one request word to the predicted state and returns the response.
   function automatic rail_report_type advance_sequencer(input logic [1:0] kind,
                                                         input logic [GOOD_COUNT-1:0] pg);
      rail_report_type word;
      logic [2:0]   top;
      logic [2:0]   bad;
      logic [2:0]   at;
      logic         fault;
      fault = 1'b0;
      case (kind)
         KIND_START: begin
            seq_fail_level = '0;
            seq_led = 1'b0;
            restart_at_level_one();
         end
         KIND_STOP: begin
            seq_phase = PH_IDLE;
            seq_level = '0;
            seq_wait = '0;
            seq_rails = '0;
         end
         KIND_TICK: begin
            if (seq_phase != PH_IDLE) begin
               if (seq_wait > 16'd1) begin
                  seq_wait--;
               end else begin
                  top = levels_in_use();
                  if (seq_level > top) seq_level = top;
                  bad = lowest_bad_level((seq_phase == PH_POWERED) ? top : seq_level, pg);
                  if (bad != '0) begin
                     // A failed check drops this level and above, then starts over.
                     at = (seq_phase == PH_POWERED) ? bad : seq_level;
                     rails_down_from(at);
                     fault = 1'b1;
                     seq_fail_level = at;
                     seq_led = ~seq_led;
                     restart_at_level_one();
                  end else if (seq_phase == PH_POWERED || seq_level >= top) begin
                     seq_phase = PH_POWERED;
                     seq_wait = wait_reload(cfg_check);
                  end else begin
                     seq_level++;
                     rails_up(seq_level);
                     seq_wait = wait_reload(cfg_settle);
                  end
               end
            end
         end
         default: ;
      endcase
      word.rail_enable          = seq_rails;
      word.status.current_level = seq_level;
      word.status.powered_up    = (seq_phase == PH_POWERED);
      word.status.fault_pulse   = fault;
      word.status.failed_level  = seq_fail_level;
      word.status.red_led       = seq_led;
      return word;
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_RAIL_LEVELS:  cfg_rail_levels = data[47:0];
         CSR_GOOD_LEVELS:  cfg_good_levels = data[41:0];
         CSR_LEVEL_COUNT:  cfg_level_count = data[2:0];
         CSR_SETTLE_TICKS: cfg_settle = data[15:0];
         CSR_CHECK_TICKS:  cfg_check = data[15:0];
         default: ;
      endcase
   endtask

   task automatic load_settings(input logic [47:0] rails, input logic [47:0] goods,
                                input logic [2:0] count, input logic [15:0] settle,
                                input logic [15:0] check);
      write_reg(CSR_RAIL_LEVELS, rails);
      write_reg(CSR_GOOD_LEVELS, goods);
      write_reg(CSR_LEVEL_COUNT, {45'd0, count});
      write_reg(CSR_SETTLE_TICKS, {32'd0, settle});
      write_reg(CSR_CHECK_TICKS, {32'd0, check});
      csr_we <= 1'b0;
   endtask

   // Mostly short waits so the sequence gets deep, with the extremes now and then.
   function automatic logic [15:0] pick_ticks();
      int unsigned r;
      r = $urandom_range(0, 19);
      if (r == 0) return 16'd0;
      if (r == 1) return 16'hFFFF;
      if (r == 2) return 16'($urandom_range(0, 65535));
      return 16'($urandom_range(1, 4));
   endfunction

   // Offers one request word after a random gap and waits for it to be taken,
   // then records the response it should cause.
   task automatic send_word(input logic [1:0] kind, input logic [GOOD_COUNT-1:0] pg,
                            input bit typed, input rail_report_type typed_word);
      int unsigned  gap;
      rail_report_type predicted;
      if ($urandom_range(0, 39) == 0) send_idle_on = !send_idle_on;
      gap = send_idle_on ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.kind       <= kind;
      req_bus.power_good <= pg;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      predicted = advance_sequencer(kind, pg);
      pending_reports.push_back(typed ? typed_word : predicted);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // Stimulus: bring-up table first, then random phases with fresh settings.
   initial begin
      int unsigned           s;
      int unsigned           p;
      int unsigned           n;
      int unsigned           j;
      int unsigned           r;
      logic [1:0]            kind;
      logic [GOOD_COUNT-1:0] used;
      logic [GOOD_COUNT-1:0] pg;
      rail_report_type       typed_word;

      req_bus.valid      <= 1'b0;
      req_bus.kind       <= KIND_TICK;
      req_bus.power_good <= '0;
      csr_we             <= 1'b0;
      csr_index          <= CSR_RAIL_LEVELS;
      csr_wdata          <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      load_settings(48'hE000_0000_0051, 48'h0380_0000_0011, 3'd2, 16'd2, 16'd2);
      for (s = 0; s < STEP_COUNT; s++) begin
         typed_word.rail_enable          = bring_up_steps[s].rails;
         typed_word.status.current_level = bring_up_steps[s].level;
         typed_word.status.powered_up    = bring_up_steps[s].up;
         typed_word.status.fault_pulse   = bring_up_steps[s].fault;
         typed_word.status.failed_level  = bring_up_steps[s].failed;
         typed_word.status.red_led       = bring_up_steps[s].led;
         send_word(bring_up_steps[s].kind, bring_up_steps[s].power_good,
                   bring_up_steps[s].typed, typed_word);
      end

      typed_word = '0;
      for (p = 0; p < PHASE_COUNT; p++) begin
         drain();
         if (p == 0) begin
            load_settings('0, '0, 3'd0, 16'd0, 16'd0);
         end else if (p == 1) begin
            load_settings('1, '1, 3'd7, 16'hFFFF, 16'hFFFF);
         end else begin
            load_settings(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                          3'($urandom_range(0, 7)), pick_ticks(), pick_ticks());
         end
         used = '0;
         for (j = 0; j < GOOD_COUNT; j++) begin
            used[j] = (level_field({6'd0, cfg_good_levels}, j) != '0);
         end

         // A start opens most phases; then mostly ticks with healthy supplies.
         for (n = 0; n < PHASE_WORDS; n++) begin
            r = $urandom_range(0, 99);
            if (n == 0 && r < 88) kind = KIND_START;
            else if (r < 3) kind = KIND_START;
            else if (r < 5) kind = KIND_STOP;
            else if (r < 7) kind = KIND_UNUSED;
            else kind = KIND_TICK;
            pg = (GOOD_COUNT'($urandom) & ~used) | used;
            r = $urandom_range(0, 19);
            if (r == 0) pg = GOOD_COUNT'($urandom);
            else if (r < 3) pg[$urandom_range(0, GOOD_COUNT - 1)] = 1'b0;
            send_word(kind, pg, 1'b0, typed_word);
         end
      end

      drain();
      repeat (4) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Response side: random ready gaps, one long hold-off, and field checks.
   initial begin
      int unsigned  gap;
      int unsigned  taken;
      bit           idle_on;
      rail_report_type want;
      taken = 0;
      idle_on = 1'b1;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0) idle_on = !idle_on;
         gap = idle_on ? $urandom_range(0, 10) : 0;
         if (taken == HOLD_AT) gap = HOLD_CYCLES;
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
         taken++;
         if (pending_reports.size() == 0) begin
            report_error($sformatf("word with nothing expected, rail_enable %h",
                                   rsp_bus.rail_enable));
         end else begin
            want = pending_reports.pop_front();
            if (rsp_bus.rail_enable !== want.rail_enable)
               report_error($sformatf("rail_enable got %h expected %h",
                                      rsp_bus.rail_enable, want.rail_enable));
            if (rsp_bus.current_level !== want.status.current_level)
               report_error($sformatf("current_level got %0d expected %0d",
                                      rsp_bus.current_level, want.status.current_level));
            if (rsp_bus.powered_up !== want.status.powered_up)
               report_error($sformatf("powered_up got %b expected %b",
                                      rsp_bus.powered_up, want.status.powered_up));
            if (rsp_bus.fault_pulse !== want.status.fault_pulse)
               report_error($sformatf("fault_pulse got %b expected %b",
                                      rsp_bus.fault_pulse, want.status.fault_pulse));
            if (rsp_bus.failed_level !== want.status.failed_level)
               report_error($sformatf("failed_level got %0d expected %0d",
                                      rsp_bus.failed_level, want.status.failed_level));
            if (rsp_bus.red_led !== want.status.red_led)
               report_error($sformatf("red_led got %b expected %b",
                                      rsp_bus.red_led, want.status.red_led));
         end
      end
   end

   // Ends the run if no word moves on either channel for too long.
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

endmodule
